/* design/gic_pkg.sv */
`timescale 1ns / 1ps

package gic_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int PIN_WIDTH   = 5;
   localparam int CMD_WIDTH   = 2;
   localparam int INDEX_WIDTH = 3;

   localparam logic [CMD_WIDTH-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE = 2'd2;

   localparam logic [INDEX_WIDTH-1:0] REG_ENABLE = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_LEVEL  = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] REG_HIGH   = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_BOTH   = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] REG_STATUS = 3'd4;

   typedef struct packed {
      logic tick;
      logic wr_enable;
      logic wr_level;
      logic wr_high;
      logic wr_both;
      logic wr_status;
   } lane_ctl_type;

   typedef struct packed {
      logic enable;
      logic level;
      logic high;
      logic both;
      logic pending;
   } lane_regs_type;

endpackage

/* design/gic_pin_lane.sv */
`timescale 1ns / 1ps

module gic_pin_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  gic_pkg::lane_ctl_type ctl,
   input  logic                  pin,
   input  logic                  wbit,
   output gic_pkg::lane_regs_type regs,
   output logic                  active
);
   import gic_pkg::*;

   logic enable_ff, enable_in;
   logic level_ff, level_in;
   logic high_ff, high_in;
   logic both_ff, both_in;
   logic pending_ff, pending_in;
   logic prev_ff, prev_in;

   logic rise, fall, chosen, edge_hit, level_hit;

   always_comb begin
      rise      = pin & ~prev_ff;
      fall      = prev_ff & ~pin;
      chosen    = high_ff ? rise : fall;
      edge_hit  = both_ff ? (rise | fall) : chosen;
      level_hit = ~(pin ^ high_ff);

      enable_in  = ctl.wr_enable ? wbit : enable_ff;
      level_in   = ctl.wr_level ? wbit : level_ff;
      high_in    = ctl.wr_high ? wbit : high_ff;
      both_in    = ctl.wr_both ? wbit : both_ff;
      prev_in    = ctl.tick ? pin : prev_ff;
      pending_in = pending_ff;
      if (ctl.tick) begin
         pending_in = level_ff ? level_hit : (pending_ff | edge_hit);
      end else if (ctl.wr_status) begin
         pending_in = pending_ff & ~(wbit & ~level_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         level_ff   <= 1'b0;
         high_ff    <= 1'b0;
         both_ff    <= 1'b0;
         pending_ff <= 1'b0;
         prev_ff    <= 1'b0;
      end else begin
         enable_ff  <= enable_in;
         level_ff   <= level_in;
         high_ff    <= high_in;
         both_ff    <= both_in;
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
      end
   end

   assign regs.enable  = enable_ff;
   assign regs.level   = level_ff;
   assign regs.high    = high_ff;
   assign regs.both    = both_ff;
   assign regs.pending = pending_ff;
   assign active       = pending_in & enable_in;

endmodule

/* design/gic_merge.sv */
`timescale 1ns / 1ps

module gic_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [gic_pkg::WORD_WIDTH-1:0]    rdata,
   input  logic [gic_pkg::WORD_WIDTH-1:0]    active,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic                              can_load,
   output logic [gic_pkg::WORD_WIDTH-1:0]    read_data,
   output logic                              irq_out,
   output logic [gic_pkg::PIN_WIDTH-1:0]     lowest_pending,
   output logic                              any_pending
);
   import gic_pkg::*;

   logic                  valid_ff, valid_in;
   logic [WORD_WIDTH-1:0] rdata_ff;
   logic                  irq_ff;
   logic [PIN_WIDTH-1:0]  lowest_ff, lowest_in;

   always_comb begin
      lowest_in = '0;
      for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
         if (active[i]) begin
            lowest_in = PIN_WIDTH'(i);
         end
      end
   end

   assign can_load = ~valid_ff | out_ready;
   assign valid_in = load | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rdata_ff  <= rdata;
         irq_ff    <= |active;
         lowest_ff <= lowest_in;
      end
   end

   assign out_valid      = valid_ff;
   assign read_data      = rdata_ff;
   assign irq_out        = irq_ff;
   assign lowest_pending = lowest_ff;
   assign any_pending    = irq_ff;

endmodule

/* design/gpio_interrupt_controller.sv */
`timescale 1ns / 1ps

// channel | direction | ports
// req     | in        | req_valid req_ready req_cmd req_reg_index req_write_data req_pin_levels
// rsp     | out       | rsp_valid rsp_ready rsp_read_data rsp_irq_out rsp_lowest_pending
//         |           | rsp_any_pending
//
// One word per cycle while rsp is not stalled; each word gives its result word in the cycle after acceptance.
// The per-pin lanes are registered; the priority encoder feeds the output register.
// Synchronous reset clears the lane registers and drops rsp_valid; the output data registers are not reset.
// While rsp is stalled with a word held, req_ready is low.
module gpio_interrupt_controller #(
   parameter int PIN_COUNT = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gic_pkg::CMD_WIDTH-1:0]       req_cmd,
   input  logic [gic_pkg::INDEX_WIDTH-1:0]     req_reg_index,
   input  logic [gic_pkg::WORD_WIDTH-1:0]      req_write_data,
   input  logic [gic_pkg::WORD_WIDTH-1:0]      req_pin_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gic_pkg::WORD_WIDTH-1:0]      rsp_read_data,
   output logic                                rsp_irq_out,
   output logic [gic_pkg::PIN_WIDTH-1:0]       rsp_lowest_pending,
   output logic                                rsp_any_pending
);
   import gic_pkg::*;

   logic                  accept;
   logic                  is_write;
   lane_ctl_type          ctl;
   logic [WORD_WIDTH-1:0] enable_vec, level_vec, high_vec, both_vec, pending_vec;
   logic [WORD_WIDTH-1:0] active_vec;
   logic [WORD_WIDTH-1:0] rdata;

   assign accept   = req_valid & req_ready;
   assign is_write = accept & (req_cmd == CMD_WRITE);

   always_comb begin
      ctl.tick      = accept & (req_cmd == CMD_TICK);
      ctl.wr_enable = is_write & (req_reg_index == REG_ENABLE);
      ctl.wr_level  = is_write & (req_reg_index == REG_LEVEL);
      ctl.wr_high   = is_write & (req_reg_index == REG_HIGH);
      ctl.wr_both   = is_write & (req_reg_index == REG_BOTH);
      ctl.wr_status = is_write & (req_reg_index == REG_STATUS);
   end

   for (genvar g = 0; g < WORD_WIDTH; g++) begin : g_lane
      if (g < PIN_COUNT) begin : g_pin
         lane_regs_type regs;

         gic_pin_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctl    (ctl),
            .pin    (req_pin_levels[g]),
            .wbit   (req_write_data[g]),
            .regs   (regs),
            .active (active_vec[g])
         );

         assign enable_vec[g]  = regs.enable;
         assign level_vec[g]   = regs.level;
         assign high_vec[g]    = regs.high;
         assign both_vec[g]    = regs.both;
         assign pending_vec[g] = regs.pending;
      end else begin : g_none
         assign active_vec[g]  = 1'b0;
         assign enable_vec[g]  = 1'b0;
         assign level_vec[g]   = 1'b0;
         assign high_vec[g]    = 1'b0;
         assign both_vec[g]    = 1'b0;
         assign pending_vec[g] = 1'b0;
      end
   end

   always_comb begin
      rdata = '0;
      if (req_cmd == CMD_READ) begin
         case (req_reg_index)
            REG_ENABLE: rdata = enable_vec;
            REG_LEVEL:  rdata = level_vec;
            REG_HIGH:   rdata = high_vec;
            REG_BOTH:   rdata = both_vec;
            REG_STATUS: rdata = pending_vec;
            default:    rdata = '0;
         endcase
      end
   end

   gic_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .rdata          (rdata),
      .active         (active_vec),
      .out_ready      (rsp_ready),
      .out_valid      (rsp_valid),
      .can_load       (req_ready),
      .read_data      (rsp_read_data),
      .irq_out        (rsp_irq_out),
      .lowest_pending (rsp_lowest_pending),
      .any_pending    (rsp_any_pending)
   );

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no result");

   a_read_only_data: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd != CMD_READ) |=> rsp_read_data == '0)
      else $error("read data nonzero for a non-read word");

   a_lowest_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_any_pending) |-> (32'(rsp_lowest_pending) < PIN_COUNT))
      else $error("lowest pending pin out of range");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   a_lowest_zero_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_any_pending) |-> (rsp_lowest_pending == '0))
      else $error("lowest pending nonzero with nothing pending");

endmodule
